// ----- hdl/mips_subset_instruction_decoder_macros.svh -----
// assertion macros used by the checker
`ifndef MIPS_SUBSET_INSTRUCTION_DECODER_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_DECODER_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define MSPD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on the block clock and reset
`define MSPD_ASSERT(label, prop, msg) \
	`MSPD_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ----- hdl/mspd_pkg.sv -----
package mspd_pkg;

	// default width of the running instruction index
	localparam int INDEX_BITS_DEF = 30;

	// byte address of instruction zero after reset
	localparam logic [31:0] TEXT_BASE_RESET = 32'h0040_0000;

	// the one word that decodes as eret
	localparam logic [31:0] ERET_WORD = 32'h4200_0018;

	// entries between classify and execute, a power of two
	localparam int QUEUE_DEPTH = 2;

	// mnemonic codes, zero is no match
	typedef enum logic [5:0] {
		MN_NONE    = 6'd0,
		MN_ERET    = 6'd1,
		MN_MFHI    = 6'd2,
		MN_MFLO    = 6'd3,
		MN_MTHI    = 6'd4,
		MN_MTLO    = 6'd5,
		MN_SLL     = 6'd6,
		MN_SRL     = 6'd7,
		MN_SRA     = 6'd8,
		MN_JR      = 6'd9,
		MN_JALR    = 6'd10,
		MN_DIV     = 6'd11,
		MN_DIVU    = 6'd12,
		MN_MULT    = 6'd13,
		MN_MULTU   = 6'd14,
		MN_BREAK   = 6'd15,
		MN_SYSCALL = 6'd16,
		MN_TEQ     = 6'd17,
		MN_ADD     = 6'd18,
		MN_ADDU    = 6'd19,
		MN_SUB     = 6'd20,
		MN_SUBU    = 6'd21,
		MN_AND     = 6'd22,
		MN_OR      = 6'd23,
		MN_XOR     = 6'd24,
		MN_NOR     = 6'd25,
		MN_SLT     = 6'd26,
		MN_SLTU    = 6'd27,
		MN_SLLV    = 6'd28,
		MN_SRLV    = 6'd29,
		MN_SRAV    = 6'd30,
		MN_BGEZ    = 6'd31,
		MN_CLZ     = 6'd32,
		MN_MUL     = 6'd33,
		MN_ADDI    = 6'd34,
		MN_ADDIU   = 6'd35,
		MN_ANDI    = 6'd36,
		MN_ORI     = 6'd37,
		MN_XORI    = 6'd38,
		MN_MFC0    = 6'd39,
		MN_MTC0    = 6'd40,
		MN_LW      = 6'd41,
		MN_SW      = 6'd42,
		MN_BEQ     = 6'd43,
		MN_BNE     = 6'd44,
		MN_SLTI    = 6'd45,
		MN_SLTIU   = 6'd46,
		MN_LUI     = 6'd47,
		MN_J       = 6'd48,
		MN_JAL     = 6'd49,
		MN_LBU     = 6'd50,
		MN_LHU     = 6'd51,
		MN_LB      = 6'd52,
		MN_LH      = 6'd53,
		MN_SB      = 6'd54,
		MN_SH      = 6'd55
	} mnem_t;

	// classification handed from front to back
	typedef struct packed {
		mnem_t mnemonic;
		logic  unlisted;
	} class_t;

endpackage

// ----- hdl/mips_subset_instruction_decoder.sv -----
// an accepted push is written into the queue, then loaded into the result register
// throughput: one word per cycle unless full or an unpopped result stalls the flow; the
// classify front, a two-entry queue and the single result register of the back end each move one beat per cycle
// reset: instruction index 0, text_base 0x00400000, queue and result empty
module mips_subset_instruction_decoder #(
	parameter int INDEX_BITS = mspd_pkg::INDEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [31:0]            instruction,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [31:0]            text_base,
	input  logic                   pop,
	output logic                   empty,
	output logic [5:0]             mnemonic,
	output logic                   unlisted_opcode,
	output logic [INDEX_BITS-1:0]  item_index,
	output logic [4:0]             reg_s,
	output logic [4:0]             reg_t,
	output logic [4:0]             reg_d,
	output logic [4:0]             shift_amount,
	output logic signed [15:0]     imm_signed,
	output logic [15:0]            imm_unsigned,
	output logic [INDEX_BITS-1:0]  target_index
);

	logic                  q_wr_en;
	logic [31:0]           q_wr_word;
	logic [INDEX_BITS-1:0] q_wr_idx;
	mspd_pkg::class_t      q_wr_cls;
	logic                  q_rd_en;
	logic [31:0]           q_rd_word;
	logic [INDEX_BITS-1:0] q_rd_idx;
	mspd_pkg::class_t      q_rd_cls;
	logic                  q_empty;

	// classify and number incoming words
	mspd_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.instruction(instruction),
		.q_full     (full),
		.q_wr_en    (q_wr_en),
		.q_wr_word  (q_wr_word),
		.q_wr_idx   (q_wr_idx),
		.q_wr_cls   (q_wr_cls)
	);

	// decoupling queue
	mspd_queue #(
		.INDEX_BITS(INDEX_BITS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr_en),
		.wr_word(q_wr_word),
		.wr_idx (q_wr_idx),
		.wr_cls (q_wr_cls),
		.full   (full),
		.rd_en  (q_rd_en),
		.rd_word(q_rd_word),
		.rd_idx (q_rd_idx),
		.rd_cls (q_rd_cls),
		.empty  (q_empty)
	);

	// targets, field split and result register
	mspd_back #(
		.INDEX_BITS(INDEX_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.text_base      (text_base),
		.q_empty        (q_empty),
		.q_rd_en        (q_rd_en),
		.q_rd_word      (q_rd_word),
		.q_rd_idx       (q_rd_idx),
		.q_rd_cls       (q_rd_cls),
		.pop            (pop),
		.empty          (empty),
		.mnemonic       (mnemonic),
		.unlisted_opcode(unlisted_opcode),
		.item_index     (item_index),
		.reg_s          (reg_s),
		.reg_t          (reg_t),
		.reg_d          (reg_d),
		.shift_amount   (shift_amount),
		.imm_signed     (imm_signed),
		.imm_unsigned   (imm_unsigned),
		.target_index   (target_index)
	);

endmodule

// ----- hdl/mspd_front.sv -----
module mspd_front #(
	parameter int INDEX_BITS = mspd_pkg::INDEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [31:0]            instruction,
	input  logic                   q_full,
	output logic                   q_wr_en,
	output logic [31:0]            q_wr_word,
	output logic [INDEX_BITS-1:0]  q_wr_idx,
	output mspd_pkg::class_t       q_wr_cls
);

	// major opcodes
	localparam logic [5:0] OP_SPECIAL  = 6'h00;
	localparam logic [5:0] OP_REGIMM   = 6'h01;
	localparam logic [5:0] OP_J        = 6'h02;
	localparam logic [5:0] OP_JAL      = 6'h03;
	localparam logic [5:0] OP_BEQ      = 6'h04;
	localparam logic [5:0] OP_BNE      = 6'h05;
	localparam logic [5:0] OP_ADDI     = 6'h08;
	localparam logic [5:0] OP_ADDIU    = 6'h09;
	localparam logic [5:0] OP_SLTI     = 6'h0A;
	localparam logic [5:0] OP_SLTIU    = 6'h0B;
	localparam logic [5:0] OP_ANDI     = 6'h0C;
	localparam logic [5:0] OP_ORI      = 6'h0D;
	localparam logic [5:0] OP_XORI     = 6'h0E;
	localparam logic [5:0] OP_LUI      = 6'h0F;
	localparam logic [5:0] OP_COP0     = 6'h10;
	localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
	localparam logic [5:0] OP_LB       = 6'h20;
	localparam logic [5:0] OP_LH       = 6'h21;
	localparam logic [5:0] OP_LW       = 6'h23;
	localparam logic [5:0] OP_LBU      = 6'h24;
	localparam logic [5:0] OP_LHU      = 6'h25;
	localparam logic [5:0] OP_SB       = 6'h28;
	localparam logic [5:0] OP_SH       = 6'h29;
	localparam logic [5:0] OP_SW       = 6'h2B;

	// special function codes
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_BREAK   = 6'h0D;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;
	localparam logic [5:0] FN_TEQ     = 6'h34;

	// special2 function codes
	localparam logic [5:0] F2_MUL = 6'h02;
	localparam logic [5:0] F2_CLZ = 6'h20;

	// regimm and cop0 selectors
	localparam logic [4:0] RT_BGEZ  = 5'd1;
	localparam logic [4:0] RS_MFC0  = 5'd0;
	localparam logic [4:0] RS_MTC0  = 5'd4;

	// classification of one word
	function automatic mspd_pkg::class_t classify(input logic [31:0] w);
		logic [5:0]       op;
		logic [4:0]       rs;
		logic [4:0]       rt;
		logic [4:0]       rd;
		logic [4:0]       sa;
		logic [5:0]       fn;
		mspd_pkg::class_t c;
		op = w[31:26];
		rs = w[25:21];
		rt = w[20:16];
		rd = w[15:11];
		sa = w[10:6];
		fn = w[5:0];
		c.mnemonic = mspd_pkg::MN_NONE;
		c.unlisted = 1'b0;
		if (w == mspd_pkg::ERET_WORD) begin
			c.mnemonic = mspd_pkg::MN_ERET;
		end else begin
			unique case (op)
				OP_SPECIAL: begin
					priority if (fn == FN_MFHI && rt == '0 && sa == '0 && rs == '0)
						c.mnemonic = mspd_pkg::MN_MFHI;
					else if (fn == FN_MFLO && rt == '0 && sa == '0 && rs == '0)
						c.mnemonic = mspd_pkg::MN_MFLO;
					else if (rt == '0 && rd == '0 && sa == '0 && fn == FN_MTHI)
						c.mnemonic = mspd_pkg::MN_MTHI;
					else if (rt == '0 && rd == '0 && sa == '0 && fn == FN_MTLO)
						c.mnemonic = mspd_pkg::MN_MTLO;
					else if (rs == '0 && fn == FN_SLL)
						c.mnemonic = mspd_pkg::MN_SLL;
					else if (rs == '0 && fn == FN_SRL)
						c.mnemonic = mspd_pkg::MN_SRL;
					else if (rs == '0 && fn == FN_SRA)
						c.mnemonic = mspd_pkg::MN_SRA;
					else if (rt == '0 && rd == '0 && sa == '0 && fn == FN_JR)
						c.mnemonic = mspd_pkg::MN_JR;
					else if (rt == '0 && fn == FN_JALR)
						c.mnemonic = mspd_pkg::MN_JALR;
					else if (rd == '0 && sa == '0 && fn == FN_DIV)
						c.mnemonic = mspd_pkg::MN_DIV;
					else if (rd == '0 && fn == FN_DIVU)
						c.mnemonic = mspd_pkg::MN_DIVU;
					else if (rd == '0 && fn == FN_MULT)
						c.mnemonic = mspd_pkg::MN_MULT;
					else if (rd == '0 && fn == FN_MULTU)
						c.mnemonic = mspd_pkg::MN_MULTU;
					else if (sa == '0) begin
						// remaining ones match the whole low eleven bits
						unique case (fn)
							FN_BREAK:   c.mnemonic = mspd_pkg::MN_BREAK;
							FN_SYSCALL: c.mnemonic = mspd_pkg::MN_SYSCALL;
							FN_TEQ:     c.mnemonic = mspd_pkg::MN_TEQ;
							FN_ADD:     c.mnemonic = mspd_pkg::MN_ADD;
							FN_ADDU:    c.mnemonic = mspd_pkg::MN_ADDU;
							FN_SUB:     c.mnemonic = mspd_pkg::MN_SUB;
							FN_SUBU:    c.mnemonic = mspd_pkg::MN_SUBU;
							FN_AND:     c.mnemonic = mspd_pkg::MN_AND;
							FN_OR:      c.mnemonic = mspd_pkg::MN_OR;
							FN_XOR:     c.mnemonic = mspd_pkg::MN_XOR;
							FN_NOR:     c.mnemonic = mspd_pkg::MN_NOR;
							FN_SLT:     c.mnemonic = mspd_pkg::MN_SLT;
							FN_SLTU:    c.mnemonic = mspd_pkg::MN_SLTU;
							FN_SLLV:    c.mnemonic = mspd_pkg::MN_SLLV;
							FN_SRLV:    c.mnemonic = mspd_pkg::MN_SRLV;
							FN_SRAV:    c.mnemonic = mspd_pkg::MN_SRAV;
							default:    c.mnemonic = mspd_pkg::MN_NONE;
						endcase
					end else
						c.mnemonic = mspd_pkg::MN_NONE;
				end
				OP_REGIMM: begin
					if (rt == RT_BGEZ)
						c.mnemonic = mspd_pkg::MN_BGEZ;
				end
				OP_SPECIAL2: begin
					priority if (sa == '0 && fn == F2_CLZ)
						c.mnemonic = mspd_pkg::MN_CLZ;
					else if (sa == '0 && fn == F2_MUL)
						c.mnemonic = mspd_pkg::MN_MUL;
					else
						c.mnemonic = mspd_pkg::MN_NONE;
				end
				OP_COP0: begin
					priority if (sa == '0 && fn == '0 && rs == RS_MFC0)
						c.mnemonic = mspd_pkg::MN_MFC0;
					else if (sa == '0 && fn == '0 && rs == RS_MTC0)
						c.mnemonic = mspd_pkg::MN_MTC0;
					else
						c.mnemonic = mspd_pkg::MN_NONE;
				end
				OP_LUI: begin
					if (rs == '0)
						c.mnemonic = mspd_pkg::MN_LUI;
				end
				OP_ADDI:  c.mnemonic = mspd_pkg::MN_ADDI;
				OP_ADDIU: c.mnemonic = mspd_pkg::MN_ADDIU;
				OP_ANDI:  c.mnemonic = mspd_pkg::MN_ANDI;
				OP_ORI:   c.mnemonic = mspd_pkg::MN_ORI;
				OP_XORI:  c.mnemonic = mspd_pkg::MN_XORI;
				OP_LW:    c.mnemonic = mspd_pkg::MN_LW;
				OP_SW:    c.mnemonic = mspd_pkg::MN_SW;
				OP_BEQ:   c.mnemonic = mspd_pkg::MN_BEQ;
				OP_BNE:   c.mnemonic = mspd_pkg::MN_BNE;
				OP_SLTI:  c.mnemonic = mspd_pkg::MN_SLTI;
				OP_SLTIU: c.mnemonic = mspd_pkg::MN_SLTIU;
				OP_J:     c.mnemonic = mspd_pkg::MN_J;
				OP_JAL:   c.mnemonic = mspd_pkg::MN_JAL;
				OP_LBU:   c.mnemonic = mspd_pkg::MN_LBU;
				OP_LHU:   c.mnemonic = mspd_pkg::MN_LHU;
				OP_LB:    c.mnemonic = mspd_pkg::MN_LB;
				OP_LH:    c.mnemonic = mspd_pkg::MN_LH;
				OP_SB:    c.mnemonic = mspd_pkg::MN_SB;
				OP_SH:    c.mnemonic = mspd_pkg::MN_SH;
				default:  c.unlisted = 1'b1;
			endcase
		end
		return c;
	endfunction

	logic                  accept;
	logic [INDEX_BITS-1:0] counter_q;

	// input beat taken when the queue has room
	assign accept = push && !q_full;

	// running instruction index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (accept) begin
			counter_q <= counter_q + INDEX_BITS'(1);
		end
	end

	// classified item into the queue
	assign q_wr_en   = accept;
	assign q_wr_word = instruction;
	assign q_wr_idx  = counter_q;
	assign q_wr_cls  = classify(instruction);

endmodule

// ----- hdl/mspd_queue.sv -----
module mspd_queue #(
	parameter int INDEX_BITS = mspd_pkg::INDEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [31:0]            wr_word,
	input  logic [INDEX_BITS-1:0]  wr_idx,
	input  mspd_pkg::class_t       wr_cls,
	output logic                   full,
	input  logic                   rd_en,
	output logic [31:0]            rd_word,
	output logic [INDEX_BITS-1:0]  rd_idx,
	output mspd_pkg::class_t       rd_cls,
	output logic                   empty
);

	localparam int DEPTH = mspd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [31:0]           word_q [DEPTH];
	logic [INDEX_BITS-1:0] idx_q  [DEPTH];
	mspd_pkg::class_t      cls_q  [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			word_q[wr_ptr_q] <= wr_word;
			idx_q[wr_ptr_q]  <= wr_idx;
			cls_q[wr_ptr_q]  <= wr_cls;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// head of the queue
	assign rd_word = word_q[rd_ptr_q];
	assign rd_idx  = idx_q[rd_ptr_q];
	assign rd_cls  = cls_q[rd_ptr_q];

endmodule

// ----- hdl/mspd_back.sv -----
module mspd_back #(
	parameter int INDEX_BITS = mspd_pkg::INDEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [31:0]            text_base,
	input  logic                   q_empty,
	output logic                   q_rd_en,
	input  logic [31:0]            q_rd_word,
	input  logic [INDEX_BITS-1:0]  q_rd_idx,
	input  mspd_pkg::class_t       q_rd_cls,
	input  logic                   pop,
	output logic                   empty,
	output logic [5:0]             mnemonic,
	output logic                   unlisted_opcode,
	output logic [INDEX_BITS-1:0]  item_index,
	output logic [4:0]             reg_s,
	output logic [4:0]             reg_t,
	output logic [4:0]             reg_d,
	output logic [4:0]             shift_amount,
	output logic signed [15:0]     imm_signed,
	output logic [15:0]            imm_unsigned,
	output logic [INDEX_BITS-1:0]  target_index
);

	logic [31:0]           text_base_q;
	logic                  out_valid_q;
	logic                  load;
	logic [31:0]           simm_ext;
	logic [INDEX_BITS-1:0] branch_tgt;
	logic [31:0]           jump_diff;
	logic [31:0]           jump_shr;
	logic [INDEX_BITS-1:0] target;

	logic [5:0]            mnemonic_q;
	logic                  unlisted_q;
	logic [INDEX_BITS-1:0] item_index_q;
	logic [31:0]           word_q;
	logic [INDEX_BITS-1:0] target_q;

	// base register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_base_q <= mspd_pkg::TEXT_BASE_RESET;
		end else if (cfg_valid) begin
			text_base_q <= text_base;
		end
	end

	// branch target: index + 1 + signed offset
	assign simm_ext   = {{16{q_rd_word[15]}}, q_rd_word[15:0]};
	assign branch_tgt = q_rd_idx + INDEX_BITS'(1) + simm_ext[INDEX_BITS-1:0];

	// jump target: byte address less base, back to word index
	assign jump_diff = {4'b0000, q_rd_word[25:0], 2'b00} - text_base_q;
	assign jump_shr  = {2'b00, jump_diff[31:2]};

	always_comb begin
		unique case (q_rd_cls.mnemonic)
			mspd_pkg::MN_BGEZ,
			mspd_pkg::MN_BEQ,
			mspd_pkg::MN_BNE: target = branch_tgt;
			mspd_pkg::MN_J,
			mspd_pkg::MN_JAL: target = jump_shr[INDEX_BITS-1:0];
			default:          target = '0;
		endcase
	end

	// output register refills while the old beat leaves
	assign load    = !q_empty && (!out_valid_q || pop);
	assign q_rd_en = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mnemonic_q   <= q_rd_cls.mnemonic;
			unlisted_q   <= q_rd_cls.unlisted;
			item_index_q <= q_rd_idx;
			word_q       <= q_rd_word;
			target_q     <= target;
		end
	end

	// result fields
	assign empty           = !out_valid_q;
	assign mnemonic        = mnemonic_q;
	assign unlisted_opcode = unlisted_q;
	assign item_index      = item_index_q;
	assign reg_s           = word_q[25:21];
	assign reg_t           = word_q[20:16];
	assign reg_d           = word_q[15:11];
	assign shift_amount    = word_q[10:6];
	assign imm_signed      = signed'(word_q[15:0]);
	assign imm_unsigned    = word_q[15:0];
	assign target_index    = target_q;

endmodule

// ----- hdl/mspd_checker.sv -----
`include "mips_subset_instruction_decoder_macros.svh"

module mspd_checker #(
	parameter int INDEX_BITS = mspd_pkg::INDEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop,
	input  logic                   empty,
	input  logic [5:0]             mnemonic,
	input  logic                   unlisted_opcode,
	input  logic [INDEX_BITS-1:0]  item_index,
	input  logic [INDEX_BITS-1:0]  target_index
);

	// back-to-back results carry consecutive indices
	`MSPD_ASSERT(a_index_step, (pop && !empty) ##1 !empty |-> item_index == INDEX_BITS'($past(item_index) + 1'b1), "result index did not advance by one")

	// only branches and jumps carry a target
	`MSPD_ASSERT(a_target_zero, !empty && mnemonic != mspd_pkg::MN_BGEZ && mnemonic != mspd_pkg::MN_BEQ && mnemonic != mspd_pkg::MN_BNE && mnemonic != mspd_pkg::MN_J && mnemonic != mspd_pkg::MN_JAL |-> target_index == '0, "target set on a non-branch beat")

	// an unhandled opcode never has a mnemonic
	`MSPD_ASSERT(a_unlisted_none, !empty && unlisted_opcode |-> mnemonic == mspd_pkg::MN_NONE, "unlisted opcode with a mnemonic")

	// a result not taken stays put
	`MSPD_ASSERT(a_result_hold, !empty && !pop |=> !empty && $stable(mnemonic) && $stable(item_index), "waiting result changed")

endmodule

bind mips_subset_instruction_decoder mspd_checker #(
	.INDEX_BITS(INDEX_BITS)
) u_checker (.*);
